// ===== sv/pdlt_pkg.sv =====
// shared types, constants and helpers for the ps2 device link transmitter
package pdlt_pkg;

  // queue sizes
  localparam int BYTE_QUEUE_DEPTH   = 9;
  localparam int PACKET_QUEUE_DEPTH = 16;
  localparam int MAX_PACKET_BYTES   = 8;
  localparam int CMD_QUEUE_DEPTH    = 2;

  // derived widths
  localparam int BQ_PTR_W = (BYTE_QUEUE_DEPTH > 1) ? $clog2(BYTE_QUEUE_DEPTH) : 1;
  localparam int BQ_CNT_W = $clog2(BYTE_QUEUE_DEPTH + 1);
  localparam int BQ_SUM_W = BQ_CNT_W + 1;
  localparam int PQ_PTR_W = (PACKET_QUEUE_DEPTH > 1) ? $clog2(PACKET_QUEUE_DEPTH) : 1;
  localparam int PQ_CNT_W = $clog2(PACKET_QUEUE_DEPTH + 1);
  localparam int PQ_SUM_W = PQ_CNT_W + 1;
  localparam int LEN_W    = $clog2(MAX_PACKET_BYTES + 1);
  localparam int LANE_W   = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
  localparam int CQ_PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

  // protocol constants
  localparam logic [7:0]  RESEND_BYTE = 8'hFE;
  localparam logic [10:0] FRAME_MASK  = 11'h7FF;
  localparam logic        STOP_BIT    = 1'b1;
  localparam logic        START_BIT   = 1'b0;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_POLL    = 1'b1
  } op_t;

  typedef enum logic {
    KIND_TX_FRAME = 1'b0,
    KIND_RX_BYTE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    RX_NONE,
    RX_BAD_PARITY,
    RX_RESEND,
    RX_DATA
  } rx_class_t;

  // one classified command between front and back
  typedef struct packed {
    op_t        op;
    logic [7:0] send_byte;
    logic       line_busy;
    logic       frame_aborted;
    logic       tx_idle;
    rx_class_t  rx_class;
    logic [7:0] rx_data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_PUSH,
    ST_TRACK,
    ST_RECV
  } back_state_t;

  typedef logic [MAX_PACKET_BYTES-1:0][7:0] packet_t;

  // odd parity over one byte
  function automatic logic odd_parity(input logic [7:0] b);
    return ~(^b);
  endfunction

  // inverted 11-bit line frame of one byte
  function automatic logic [10:0] make_frame(input logic [7:0] b);
    return {STOP_BIT, odd_parity(b), b, START_BIT} ^ FRAME_MASK;
  endfunction

endpackage

// ===== sv/ps2_device_link_transmitter_top.sv =====
// top level of the ps2 device link transmitter
//
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// command   | start in, busy out     | operation, send_byte, line_busy,
//           |                        | frame_aborted, tx_idle, rx_valid, rx_frame
// result    | result_strobe out      | kind, tx_word, rx_byte, previous_rx_byte,
//           |                        | end_of_run
//
// an enqueue occupies the back end for its dispatch step alone; a poll takes a dispatch
// step, a byte-per-cycle gather of up to 8 queued bytes into a packet, a push step when
// bytes were gathered, a track step and a receive step when a host frame came. every
// transaction first passes through a two-entry command queue that lets the front
// accept while the back works; busy is high only while that queue is full. rst is
// synchronous and clears all control state. results are strobed for one cycle each,
// up to two per poll, each in the cycle after the track or receive step that makes it.
module ps2_device_link_transmitter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [7:0]  send_byte,
  input  logic        line_busy,
  input  logic        frame_aborted,
  input  logic        tx_idle,
  input  logic        rx_valid,
  input  logic [8:0]  rx_frame,
  output logic        result_strobe,
  output logic        kind,
  output logic [10:0] tx_word,
  output logic [7:0]  rx_byte,
  output logic [7:0]  previous_rx_byte,
  output logic        end_of_run
);

  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_not_empty;
  pdlt_pkg::cmd_t push_cmd;
  pdlt_pkg::cmd_t head_cmd;

  // command intake
  pdlt_front u_front (
    .start         (start),
    .operation     (operation),
    .send_byte     (send_byte),
    .line_busy     (line_busy),
    .frame_aborted (frame_aborted),
    .tx_idle       (tx_idle),
    .rx_valid      (rx_valid),
    .rx_frame      (rx_frame),
    .queue_full    (queue_full),
    .busy          (busy),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // decoupling queue
  pdlt_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .full      (queue_full),
    .head_cmd  (head_cmd)
  );

  // execution
  pdlt_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (queue_not_empty),
    .cmd              (head_cmd),
    .pop              (pop),
    .result_strobe    (result_strobe),
    .kind             (kind),
    .tx_word          (tx_word),
    .rx_byte          (rx_byte),
    .previous_rx_byte (previous_rx_byte),
    .end_of_run       (end_of_run)
  );

endmodule

// ===== sv/pdlt_front.sv =====
// front end: accepts commands and classifies any received host frame
module pdlt_front (
  input  logic                  start,
  input  logic                  operation,
  input  logic [7:0]            send_byte,
  input  logic                  line_busy,
  input  logic                  frame_aborted,
  input  logic                  tx_idle,
  input  logic                  rx_valid,
  input  logic [8:0]            rx_frame,
  input  logic                  queue_full,
  output logic                  busy,
  output logic                  push,
  output pdlt_pkg::cmd_t        push_cmd
);

  pdlt_pkg::rx_class_t rx_class;

  // host frame classification
  always_comb begin
    if (!rx_valid) begin
      rx_class = pdlt_pkg::RX_NONE;
    end else if (rx_frame[8] != pdlt_pkg::odd_parity(rx_frame[7:0])) begin
      rx_class = pdlt_pkg::RX_BAD_PARITY;
    end else if (rx_frame[7:0] == pdlt_pkg::RESEND_BYTE) begin
      rx_class = pdlt_pkg::RX_RESEND;
    end else begin
      rx_class = pdlt_pkg::RX_DATA;
    end
  end

  // command build and handshake
  assign busy = queue_full;
  assign push = start && !queue_full;

  always_comb begin
    push_cmd.op            = pdlt_pkg::op_t'(operation);
    push_cmd.send_byte     = send_byte;
    push_cmd.line_busy     = line_busy;
    push_cmd.frame_aborted = frame_aborted;
    push_cmd.tx_idle       = tx_idle;
    push_cmd.rx_class      = rx_class;
    push_cmd.rx_data       = rx_frame[7:0];
  end

endmodule

// ===== sv/pdlt_cmd_queue.sv =====
// short command queue between front and back
module pdlt_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pdlt_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           not_empty,
  output logic           full,
  output pdlt_pkg::cmd_t head_cmd
);

  pdlt_pkg::cmd_t                    entries [pdlt_pkg::CMD_QUEUE_DEPTH];
  logic [pdlt_pkg::CQ_PTR_W-1:0]     wr_ptr;
  logic [pdlt_pkg::CQ_PTR_W-1:0]     rd_ptr;
  logic [pdlt_pkg::CQ_CNT_W-1:0]     count;

  function automatic logic [pdlt_pkg::CQ_PTR_W-1:0] ptr_inc(
    input logic [pdlt_pkg::CQ_PTR_W-1:0] p
  );
    if (p == pdlt_pkg::CQ_PTR_W'(pdlt_pkg::CMD_QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + pdlt_pkg::CQ_PTR_W'(1);
  endfunction

  assign not_empty = (count != '0);
  assign full      = (count == pdlt_pkg::CQ_CNT_W'(pdlt_pkg::CMD_QUEUE_DEPTH));
  assign head_cmd  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + pdlt_pkg::CQ_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - pdlt_pkg::CQ_CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/pdlt_back.sv =====
// back end: byte queue, packet queue, framing and host frame handling
module pdlt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  pdlt_pkg::cmd_t cmd,
  output logic           pop,
  output logic           result_strobe,
  output logic           kind,
  output logic [10:0]    tx_word,
  output logic [7:0]     rx_byte,
  output logic [7:0]     previous_rx_byte,
  output logic           end_of_run
);

  localparam int BQD = pdlt_pkg::BYTE_QUEUE_DEPTH;
  localparam int PQD = pdlt_pkg::PACKET_QUEUE_DEPTH;
  localparam int BPW = pdlt_pkg::BQ_PTR_W;
  localparam int BCW = pdlt_pkg::BQ_CNT_W;
  localparam int BSW = pdlt_pkg::BQ_SUM_W;
  localparam int PPW = pdlt_pkg::PQ_PTR_W;
  localparam int PCW = pdlt_pkg::PQ_CNT_W;
  localparam int PSW = pdlt_pkg::PQ_SUM_W;
  localparam int LW  = pdlt_pkg::LEN_W;
  localparam int NW  = pdlt_pkg::LANE_W;

  // storage
  logic [7:0]          byte_mem [BQD];
  pdlt_pkg::packet_t   pkt_mem  [PQD];
  logic [LW-1:0]       len_mem  [PQD];

  // control and working registers
  pdlt_pkg::back_state_t state, state_next;
  pdlt_pkg::cmd_t      item, item_next;
  logic [BPW-1:0]      bhead, bhead_next;
  logic [BCW-1:0]      bcount, bcount_next;
  logic [PPW-1:0]      phead, phead_next;
  logic [PCW-1:0]      pcount, pcount_next;
  logic [LW-1:0]       sidx, sidx_next;
  logic [1:0]          busy_flags, busy_flags_next;
  logic [7:0]          last_sent, last_sent_next;
  logic [7:0]          last_rx, last_rx_next;
  logic [LW-1:0]       take, take_next;
  logic [NW-1:0]       lane, lane_next;
  pdlt_pkg::packet_t   acc, acc_next;

  // output registers
  logic                strobe_next;
  logic                kind_next;
  logic [10:0]         tx_word_next;
  logic [7:0]          rx_byte_next;
  logic [7:0]          prev_next;
  logic                eor_next;

  // write ports
  logic                bq_we;
  logic [BPW-1:0]      bq_waddr;
  logic                pq_we;
  logic [PPW-1:0]      pq_waddr;

  // registered read data
  logic [7:0]          bq_rdata;
  pdlt_pkg::packet_t   head_pkt;
  logic [LW-1:0]       head_len;

  // helpers
  logic [BSW-1:0]      btail_sum;
  logic [BPW-1:0]      btail;
  logic [PSW-1:0]      ptail_sum;
  logic [PPW-1:0]      ptail;
  logic [1:0]          busy_upd;
  logic [LW-1:0]       sidx_upd;
  logic [7:0]          head_byte;

  function automatic logic [BPW-1:0] binc(input logic [BPW-1:0] p);
    if (p == BPW'(BQD - 1)) begin
      return '0;
    end
    return p + BPW'(1);
  endfunction

  function automatic logic [PPW-1:0] pinc(input logic [PPW-1:0] p);
    if (p == PPW'(PQD - 1)) begin
      return '0;
    end
    return p + PPW'(1);
  endfunction

  // tail positions of the two circular queues
  always_comb begin
    btail_sum = BSW'(bhead) + BSW'(bcount);
    if (btail_sum >= BSW'(BQD)) begin
      btail_sum = btail_sum - BSW'(BQD);
    end
    btail = btail_sum[BPW-1:0];
    ptail_sum = PSW'(phead) + PSW'(pcount);
    if (ptail_sum >= PSW'(PQD)) begin
      ptail_sum = ptail_sum - PSW'(PQD);
    end
    ptail = ptail_sum[PPW-1:0];
  end

  // tracking updates and the byte of the head packet to send
  always_comb begin
    busy_upd  = item.line_busy ? 2'b01 : {busy_flags[1], 1'b0};
    sidx_upd  = (item.frame_aborted && sidx != '0) ? sidx - LW'(1) : sidx;
    head_byte = head_pkt[sidx_upd[NW-1:0]];
  end

  // sequencer: next state, datapath and results
  always_comb begin
    state_next      = state;
    item_next       = item;
    bhead_next      = bhead;
    bcount_next     = bcount;
    phead_next      = phead;
    pcount_next     = pcount;
    sidx_next       = sidx;
    busy_flags_next = busy_flags;
    last_sent_next  = last_sent;
    last_rx_next    = last_rx;
    take_next       = take;
    lane_next       = lane;
    acc_next        = acc;
    strobe_next     = 1'b0;
    kind_next       = kind;
    tx_word_next    = tx_word;
    rx_byte_next    = rx_byte;
    prev_next       = previous_rx_byte;
    eor_next        = end_of_run;
    bq_we           = 1'b0;
    bq_waddr        = btail;
    pq_we           = 1'b0;
    pq_waddr        = ptail;
    pop             = 1'b0;

    unique case (state)
      pdlt_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          pop       = 1'b1;
          item_next = cmd;
          if (cmd.op == pdlt_pkg::OP_ENQUEUE) begin
            // append byte, drop when full
            if (bcount < BCW'(BQD)) begin
              bq_we       = 1'b1;
              bcount_next = bcount + BCW'(1);
            end
          end else if (bcount != '0) begin
            take_next  = (bcount > BCW'(pdlt_pkg::MAX_PACKET_BYTES)) ?
                         LW'(pdlt_pkg::MAX_PACKET_BYTES) : LW'(bcount);
            lane_next  = '0;
            acc_next   = '0;
            state_next = pdlt_pkg::ST_GATHER;
          end else begin
            state_next = pdlt_pkg::ST_TRACK;
          end
        end
      end

      pdlt_pkg::ST_GATHER: begin
        // one byte per cycle from the byte queue head
        acc_next[lane] = bq_rdata;
        bhead_next     = binc(bhead);
        bcount_next    = bcount - BCW'(1);
        lane_next      = lane + NW'(1);
        if (LW'(lane) == take - LW'(1)) begin
          state_next = pdlt_pkg::ST_PUSH;
        end
      end

      pdlt_pkg::ST_PUSH: begin
        // packet lost when the packet queue is full
        if (pcount < PCW'(PQD)) begin
          pq_we       = 1'b1;
          pcount_next = pcount + PCW'(1);
        end
        state_next = pdlt_pkg::ST_TRACK;
      end

      pdlt_pkg::ST_TRACK: begin
        busy_flags_next = busy_upd;
        sidx_next       = sidx_upd;
        if (pcount != '0 && item.tx_idle && busy_upd == 2'b00) begin
          if (sidx_upd >= head_len) begin
            // retire head packet
            sidx_next   = '0;
            phead_next  = pinc(phead);
            pcount_next = pcount - PCW'(1);
          end else begin
            // send next byte of head packet
            last_sent_next  = head_byte;
            sidx_next       = sidx_upd + LW'(1);
            busy_flags_next = busy_upd | 2'b10;
            strobe_next     = 1'b1;
            kind_next       = pdlt_pkg::KIND_TX_FRAME;
            tx_word_next    = pdlt_pkg::make_frame(head_byte);
            rx_byte_next    = '0;
            prev_next       = '0;
            eor_next        = (item.rx_class == pdlt_pkg::RX_NONE);
          end
        end
        state_next = (item.rx_class == pdlt_pkg::RX_NONE) ?
                     pdlt_pkg::ST_IDLE : pdlt_pkg::ST_RECV;
      end

      pdlt_pkg::ST_RECV: begin
        eor_next   = 1'b1;
        state_next = pdlt_pkg::ST_IDLE;
        unique case (item.rx_class)
          pdlt_pkg::RX_BAD_PARITY: begin
            strobe_next  = 1'b1;
            kind_next    = pdlt_pkg::KIND_TX_FRAME;
            tx_word_next = pdlt_pkg::make_frame(pdlt_pkg::RESEND_BYTE);
            rx_byte_next = '0;
            prev_next    = '0;
          end
          pdlt_pkg::RX_RESEND: begin
            strobe_next  = 1'b1;
            kind_next    = pdlt_pkg::KIND_TX_FRAME;
            tx_word_next = pdlt_pkg::make_frame(last_sent);
            rx_byte_next = '0;
            prev_next    = '0;
          end
          pdlt_pkg::RX_DATA: begin
            // flush both queues and deliver
            bcount_next  = '0;
            pcount_next  = '0;
            strobe_next  = 1'b1;
            kind_next    = pdlt_pkg::KIND_RX_BYTE;
            tx_word_next = '0;
            rx_byte_next = item.rx_data;
            prev_next    = last_rx;
            last_rx_next = item.rx_data;
          end
          default: begin
            strobe_next = 1'b0;
          end
        endcase
      end

      default: begin
        state_next = pdlt_pkg::ST_IDLE;
      end
    endcase
  end

  // byte queue storage, head byte registered from the next head pointer
  always_ff @(posedge clk) begin
    if (bq_we) begin
      byte_mem[bq_waddr] <= item_next.send_byte;
    end
    bq_rdata <= byte_mem[bhead_next];
  end

  // packet queue storage
  always_ff @(posedge clk) begin
    if (pq_we) begin
      pkt_mem[pq_waddr] <= acc;
      len_mem[pq_waddr] <= take;
    end
  end

  // head packet read, a packet pushed into an empty queue is forwarded
  always_ff @(posedge clk) begin
    if (pq_we && pq_waddr == phead_next) begin
      head_pkt <= acc;
      head_len <= take;
    end else begin
      head_pkt <= pkt_mem[phead_next];
      head_len <= len_mem[phead_next];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdlt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bhead         <= '0;
      bcount        <= '0;
      phead         <= '0;
      pcount        <= '0;
      sidx          <= '0;
      busy_flags    <= '0;
      last_sent     <= '0;
      last_rx       <= '0;
      result_strobe <= 1'b0;
    end else begin
      bhead         <= bhead_next;
      bcount        <= bcount_next;
      phead         <= phead_next;
      pcount        <= pcount_next;
      sidx          <= sidx_next;
      busy_flags    <= busy_flags_next;
      last_sent     <= last_sent_next;
      last_rx       <= last_rx_next;
      result_strobe <= strobe_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item             <= item_next;
    take             <= take_next;
    lane             <= lane_next;
    acc              <= acc_next;
    kind             <= kind_next;
    tx_word          <= tx_word_next;
    rx_byte          <= rx_byte_next;
    previous_rx_byte <= prev_next;
    end_of_run       <= eor_next;
  end

endmodule
